### rtl/core/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// shared constants, codes and types of the biquad filter section
// ----------------------------------------------------------------------------
package bqf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 24;
    localparam int COEF_FRAC_BITS = 20;
    localparam int ACC_BITS       = 48;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_BITS       = ACC_BITS + 2;
    localparam int RND_BITS       = ACC_BITS + 1;
    localparam int SHR_BITS       = RND_BITS - COEF_FRAC_BITS;

    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = COEF_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_B0   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B1   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B2   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A1   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A2   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FORM = 3'd5;

    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}} << 1;

    localparam logic FORM_DF1 = 1'b0;
    localparam logic FORM_TDF = 1'b1;

    // multiplier coefficient select
    localparam logic [2:0] C_B0 = 3'd0;
    localparam logic [2:0] C_B1 = 3'd1;
    localparam logic [2:0] C_B2 = 3'd2;
    localparam logic [2:0] C_A1 = 3'd3;
    localparam logic [2:0] C_A2 = 3'd4;

    // multiplier sample select
    localparam logic [2:0] D_X  = 3'd0;
    localparam logic [2:0] D_H1 = 3'd1;
    localparam logic [2:0] D_H2 = 3'd2;
    localparam logic [2:0] D_O1 = 3'd3;
    localparam logic [2:0] D_O2 = 3'd4;
    localparam logic [2:0] D_Y  = 3'd5;

    // accumulator operation
    localparam logic [2:0] ACC_NONE   = 3'd0;
    localparam logic [2:0] ACC_LOAD_P = 3'd1;
    localparam logic [2:0] ACC_ADD_P  = 3'd2;
    localparam logic [2:0] ACC_SUB_P  = 3'd3;
    localparam logic [2:0] ACC_ADD_T1 = 3'd4;
    localparam logic [2:0] ACC_ADD_T2 = 3'd5;

    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] LAST_DF1 = 4'd7;
    localparam logic [STEP_BITS-1:0] LAST_TDF = 4'd9;

    typedef struct packed {
        logic       start;
        logic       mul_en;
        logic [2:0] coef_sel;
        logic [2:0] data_sel;
        logic [2:0] acc_op;
        logic       round_en;
        logic       st_t1;
        logic       st_t2;
        logic       commit_df1;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic form;
        logic out_free;
    } t_status;

endpackage

### rtl/core/bqf_smp_if.sv
// ----------------------------------------------------------------------------
// bqf_smp_if
// input sample channel: valid, ready, sample and restart flag
// ----------------------------------------------------------------------------
interface bqf_smp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bqf_pkg::SAMPLE_BITS-1:0] sample_in;
    logic                                   restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

### rtl/core/bqf_res_if.sv
// ----------------------------------------------------------------------------
// bqf_res_if
// result channel: valid, ready, filtered sample and clip flag
// ----------------------------------------------------------------------------
interface bqf_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bqf_pkg::SAMPLE_BITS-1:0] sample_out;
    logic                                   clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

### rtl/core/bqf_datapath.sv
// ----------------------------------------------------------------------------
// bqf_datapath
// coefficient registers, filter history, shared multiplier, accumulator,
// rounding and output register
// ----------------------------------------------------------------------------
module bqf_datapath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [bqf_pkg::CFG_IDX_BITS-1:0]          i_cfg_idx,
    input  logic [bqf_pkg::CFG_DATA_BITS-1:0]         i_cfg_data,
    input  bqf_pkg::t_cmd                             i_cmd,
    output bqf_pkg::t_status                          o_status,
    input  logic signed [bqf_pkg::SAMPLE_BITS-1:0]    i_sample_in,
    input  logic                                      i_restart,
    input  logic                                      i_out_ready,
    output logic                                      o_out_valid,
    output logic signed [bqf_pkg::SAMPLE_BITS-1:0]    o_sample_out,
    output logic                                      o_clipped
);

    logic signed [bqf_pkg::COEF_BITS-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic                                   r_form;
    logic signed [bqf_pkg::SAMPLE_BITS-1:0] r_x, r_h1, r_h2, r_o1, r_o2, r_y;
    logic signed [bqf_pkg::ACC_BITS-1:0]    r_t1, r_t2, r_acc;
    logic signed [bqf_pkg::PROD_BITS-1:0]   r_p;
    logic                                   r_flag;
    logic                                   r_out_valid;
    logic signed [bqf_pkg::SAMPLE_BITS-1:0] r_out_sample;
    logic                                   r_out_clip;

    logic signed [bqf_pkg::COEF_BITS-1:0]   w_coef;
    logic signed [bqf_pkg::SAMPLE_BITS-1:0] w_data;
    logic signed [bqf_pkg::PROD_BITS-1:0]   w_prod;
    logic signed [bqf_pkg::SUM_BITS-1:0]    w_base, w_opnd, w_sum;
    logic [bqf_pkg::SUM_BITS-bqf_pkg::ACC_BITS:0] w_sum_top;
    logic                                   w_acc_fits;
    logic signed [bqf_pkg::ACC_BITS-1:0]    w_acc_sat;
    logic signed [bqf_pkg::RND_BITS-1:0]    w_rnd;
    logic signed [bqf_pkg::SHR_BITS-1:0]    w_shr;
    logic [bqf_pkg::SHR_BITS-bqf_pkg::SAMPLE_BITS:0] w_shr_top;
    logic                                   w_y_fits;
    logic signed [bqf_pkg::SAMPLE_BITS-1:0] w_y_sat;
    logic                                   w_out_free;

    localparam logic signed [bqf_pkg::RND_BITS-1:0] RND_HALF =
        {{(bqf_pkg::RND_BITS-bqf_pkg::COEF_FRAC_BITS){1'b0}}, 1'b1,
         {(bqf_pkg::COEF_FRAC_BITS-1){1'b0}}};

    // multiplier operands
    always_comb begin
        case (i_cmd.coef_sel)
            bqf_pkg::C_B0: w_coef = r_b0;
            bqf_pkg::C_B1: w_coef = r_b1;
            bqf_pkg::C_B2: w_coef = r_b2;
            bqf_pkg::C_A1: w_coef = r_a1;
            bqf_pkg::C_A2: w_coef = r_a2;
            default:       w_coef = r_b0;
        endcase
        case (i_cmd.data_sel)
            bqf_pkg::D_X:  w_data = r_x;
            bqf_pkg::D_H1: w_data = r_h1;
            bqf_pkg::D_H2: w_data = r_h2;
            bqf_pkg::D_O1: w_data = r_o1;
            bqf_pkg::D_O2: w_data = r_o2;
            bqf_pkg::D_Y:  w_data = r_y;
            default:       w_data = r_x;
        endcase
    end

    assign w_prod = w_coef * w_data;

    // accumulator with saturation to the accumulator width
    always_comb begin
        w_base = (i_cmd.acc_op == bqf_pkg::ACC_LOAD_P) ? '0 : bqf_pkg::SUM_BITS'(r_acc);
        case (i_cmd.acc_op)
            bqf_pkg::ACC_LOAD_P: w_opnd = bqf_pkg::SUM_BITS'(r_p);
            bqf_pkg::ACC_ADD_P:  w_opnd = bqf_pkg::SUM_BITS'(r_p);
            bqf_pkg::ACC_SUB_P:  w_opnd = -bqf_pkg::SUM_BITS'(r_p);
            bqf_pkg::ACC_ADD_T1: w_opnd = bqf_pkg::SUM_BITS'(r_t1);
            bqf_pkg::ACC_ADD_T2: w_opnd = bqf_pkg::SUM_BITS'(r_t2);
            default:             w_opnd = '0;
        endcase
        w_sum      = w_base + w_opnd;
        w_sum_top  = w_sum[bqf_pkg::SUM_BITS-1:bqf_pkg::ACC_BITS-1];
        w_acc_fits = (&w_sum_top) | ~(|w_sum_top);
        if (w_acc_fits) begin
            w_acc_sat = w_sum[bqf_pkg::ACC_BITS-1:0];
        end else if (w_sum[bqf_pkg::SUM_BITS-1]) begin
            w_acc_sat = {1'b1, {(bqf_pkg::ACC_BITS-1){1'b0}}};
        end else begin
            w_acc_sat = {1'b0, {(bqf_pkg::ACC_BITS-1){1'b1}}};
        end
    end

    // round to nearest, shift and saturate to the sample width
    always_comb begin
        w_rnd     = bqf_pkg::RND_BITS'(r_acc) + RND_HALF;
        w_shr     = w_rnd[bqf_pkg::RND_BITS-1:bqf_pkg::COEF_FRAC_BITS];
        w_shr_top = w_shr[bqf_pkg::SHR_BITS-1:bqf_pkg::SAMPLE_BITS-1];
        w_y_fits  = (&w_shr_top) | ~(|w_shr_top);
        if (w_y_fits) begin
            w_y_sat = w_shr[bqf_pkg::SAMPLE_BITS-1:0];
        end else if (w_shr[bqf_pkg::SHR_BITS-1]) begin
            w_y_sat = {1'b1, {(bqf_pkg::SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_y_sat = {1'b0, {(bqf_pkg::SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign w_out_free = ~r_out_valid | i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0   <= bqf_pkg::COEF_ONE;
            r_b1   <= '0;
            r_b2   <= '0;
            r_a1   <= '0;
            r_a2   <= '0;
            r_form <= bqf_pkg::FORM_DF1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bqf_pkg::CFG_B0:   r_b0   <= i_cfg_data;
                bqf_pkg::CFG_B1:   r_b1   <= i_cfg_data;
                bqf_pkg::CFG_B2:   r_b2   <= i_cfg_data;
                bqf_pkg::CFG_A1:   r_a1   <= i_cfg_data;
                bqf_pkg::CFG_A2:   r_a2   <= i_cfg_data;
                bqf_pkg::CFG_FORM: r_form <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // filter history of both forms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1 <= '0;
            r_h2 <= '0;
            r_o1 <= '0;
            r_o2 <= '0;
            r_t1 <= '0;
            r_t2 <= '0;
        end else if (i_cmd.start && i_restart) begin
            r_h1 <= '0;
            r_h2 <= '0;
            r_o1 <= '0;
            r_o2 <= '0;
            r_t1 <= '0;
            r_t2 <= '0;
        end else begin
            if (i_cmd.commit_df1) begin
                r_h2 <= r_h1;
                r_h1 <= r_x;
                r_o2 <= r_o1;
                r_o1 <= r_y;
            end
            if (i_cmd.st_t1) begin
                r_t1 <= r_acc;
            end
            if (i_cmd.st_t2) begin
                r_t2 <= r_acc;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul_en) begin
            r_p <= w_prod;
        end
        if (i_cmd.acc_op != bqf_pkg::ACC_NONE) begin
            r_acc <= w_acc_sat;
        end
        if (i_cmd.round_en) begin
            r_y <= w_y_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_cmd.start) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= r_flag
                    | ((i_cmd.acc_op != bqf_pkg::ACC_NONE) & ~w_acc_fits)
                    | (i_cmd.round_en & ~w_y_fits);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_sample <= r_y;
            r_out_clip   <= r_flag;
        end
    end

    assign o_status.form     = r_form;
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_out_sample;
    assign o_clipped         = r_out_clip;

`ifndef SYNTHESIS
    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> w_out_free)
        else $error("result loaded over an untaken result");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start && i_restart) |=> (r_t1 == '0 && r_t2 == '0 && r_h1 == '0
                                        && r_o1 == '0))
        else $error("restart did not clear history");

    a_single_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.commit_df1 && (i_cmd.st_t1 || i_cmd.st_t2)))
        else $error("both forms updated in one cycle");
`endif

endmodule

### rtl/core/bqf_ctrl.sv
// ----------------------------------------------------------------------------
// bqf_ctrl
// sequencer: issues multiply, accumulate, round and store commands for
// the selected filter form, one sample at a time
// ----------------------------------------------------------------------------
module bqf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bqf_pkg::t_status i_status,
    output bqf_pkg::t_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                          r_state, n_state;
    logic [bqf_pkg::STEP_BITS-1:0] r_step, n_step;
    logic [bqf_pkg::STEP_BITS-1:0] w_last;
    bqf_pkg::t_cmd                 w_cmd;

    assign w_last = (i_status.form == bqf_pkg::FORM_TDF) ? bqf_pkg::LAST_TDF
                                                          : bqf_pkg::LAST_DF1;

    // command table per step
    always_comb begin
        w_cmd = '0;
        if (i_status.form == bqf_pkg::FORM_DF1) begin
            case (r_step)
                4'd0: begin
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_B0;
                    w_cmd.data_sel = bqf_pkg::D_X;
                end
                4'd1: begin
                    w_cmd.acc_op = bqf_pkg::ACC_LOAD_P;
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_B1;
                    w_cmd.data_sel = bqf_pkg::D_H1;
                end
                4'd2: begin
                    w_cmd.acc_op = bqf_pkg::ACC_ADD_P;
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_B2;
                    w_cmd.data_sel = bqf_pkg::D_H2;
                end
                4'd3: begin
                    w_cmd.acc_op = bqf_pkg::ACC_ADD_P;
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_A1;
                    w_cmd.data_sel = bqf_pkg::D_O1;
                end
                4'd4: begin
                    w_cmd.acc_op = bqf_pkg::ACC_SUB_P;
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_A2;
                    w_cmd.data_sel = bqf_pkg::D_O2;
                end
                4'd5: w_cmd.acc_op = bqf_pkg::ACC_SUB_P;
                4'd6: w_cmd.round_en = 1'b1;
                4'd7: begin
                    w_cmd.commit_df1 = 1'b1;
                    w_cmd.load_out   = 1'b1;
                end
                default: w_cmd = '0;
            endcase
        end else begin
            case (r_step)
                4'd0: begin
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_B0;
                    w_cmd.data_sel = bqf_pkg::D_X;
                end
                4'd1: w_cmd.acc_op = bqf_pkg::ACC_LOAD_P;
                4'd2: w_cmd.acc_op = bqf_pkg::ACC_ADD_T1;
                4'd3: begin
                    w_cmd.round_en = 1'b1;
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_B1;
                    w_cmd.data_sel = bqf_pkg::D_X;
                end
                4'd4: begin
                    w_cmd.acc_op = bqf_pkg::ACC_LOAD_P;
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_A1;
                    w_cmd.data_sel = bqf_pkg::D_Y;
                end
                4'd5: w_cmd.acc_op = bqf_pkg::ACC_SUB_P;
                4'd6: begin
                    w_cmd.acc_op = bqf_pkg::ACC_ADD_T2;
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_B2;
                    w_cmd.data_sel = bqf_pkg::D_X;
                end
                4'd7: begin
                    w_cmd.st_t1  = 1'b1;
                    w_cmd.acc_op = bqf_pkg::ACC_LOAD_P;
                    w_cmd.mul_en = 1'b1; w_cmd.coef_sel = bqf_pkg::C_A2;
                    w_cmd.data_sel = bqf_pkg::D_Y;
                end
                4'd8: w_cmd.acc_op = bqf_pkg::ACC_SUB_P;
                4'd9: begin
                    w_cmd.st_t2    = 1'b1;
                    w_cmd.load_out = 1'b1;
                end
                default: w_cmd = '0;
            endcase
        end
    end

    // state sequencing, last step waits for a free output register
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.start = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                if (r_step == w_last) begin
                    if (i_status.out_free) begin
                        o_cmd   = w_cmd;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd  = w_cmd;
                    n_step = r_step + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_RUN && r_step == '0))
        else $error("accepted sample did not start the sequence");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step <= w_last))
        else $error("step counter beyond last step");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == w_last && !i_status.out_free)
            |=> (r_state == S_RUN && $stable(r_step)))
        else $error("last step left while output register full");
`endif

endmodule

### rtl/core/biquad_iir_filter_two_form.sv
// samples: one at a time; a new sample is not accepted until the last one has been
// loaded into the result register, which may stall while that register is full
// products: the five products of each sample go one at a time through the single
// shared multiplier
// reset: synchronous, active low; coefficients return to b0 = 1.0, others 0,
// form I selected, all filter history cleared, no result pending
// ----------------------------------------------------------------------------
// biquad_iir_filter_two_form
// second-order iir section, direct form I or transposed direct form II,
// Q4.20 coefficients, rounded and saturated 16-bit output
// ----------------------------------------------------------------------------
module biquad_iir_filter_two_form (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bqf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [bqf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    bqf_smp_if.sink                           i_smp,
    bqf_res_if.source                         o_res
);

    bqf_pkg::t_cmd    w_cmd;
    bqf_pkg::t_status w_status;

    bqf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bqf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_sample_in  (i_smp.sample_in),
        .i_restart    (i_smp.restart),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_sample_out (o_res.sample_out),
        .o_clipped    (o_res.clipped)
    );

endmodule
